// File: hdl/lua_pkg.sv
// Leased unit allocator: shared constants, widths and controller/datapath structs.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lua_pkg;

  localparam int MAX_UNITS = 128;
  localparam int IDX_W     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int PTR_W     = $clog2(MAX_UNITS + 1);

  localparam int ARR_W  = 20;
  localparam int CNT_W  = 8;
  localparam int LEN_W  = 16;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 14;
  localparam int CFG_W  = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(128);

  // Controller -> datapath.
  typedef struct packed {
    logic load_item;
    logic run_count;
    logic start_assign;
    logic run_assign;
    logic load_result;
  } lua_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic pass_done;
    logic enough;
    logic out_free;
  } lua_sts_t;

endpackage

// File: hdl/lua_req_if.sv
// Request channel interface: valid/ready plus the request item fields.
// Depends on lua_pkg.
`timescale 1ns / 1ps

interface lua_req_if;
  import lua_pkg::*;

  logic             valid;
  logic             ready;
  logic [ARR_W-1:0] arrival_time;
  logic [CNT_W-1:0] unit_count;
  logic [LEN_W-1:0] lease_length;

  modport source (output valid, arrival_time, unit_count, lease_length, input ready);
  modport sink   (input valid, arrival_time, unit_count, lease_length, output ready);
endinterface

// File: hdl/lua_rsp_if.sv
// Result channel interface: valid/ready plus the result item fields.
// Depends on lua_pkg.
`timescale 1ns / 1ps

interface lua_rsp_if;
  import lua_pkg::*;

  logic             valid;
  logic             ready;
  logic             granted;
  logic [SUM_W-1:0] unit_sum;

  modport source (output valid, granted, unit_sum, input ready);
  modport sink   (input valid, granted, unit_sum, output ready);
endinterface

// File: hdl/leased_unit_allocator.sv
// Leased unit allocator top level: wires controller and datapath to the channels.
// Depends on lua_pkg, lua_req_if, lua_rsp_if, lua_ctrl, lua_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   req_i  - request items (arrival_time, unit_count, lease_length), valid/ready.
//   rsp_o  - one result item per request (granted, unit_sum), valid/ready.
//   cfg_we_i / cfg_wdata_i - writes units_in_use; write only while idle.
// Each item runs a count pass and, if enough units are free, an assign pass
// over the busy-until table, one table entry per cycle through a registered
// read port. With pool = min(units_in_use, 128), each pass reads entries
// 0 to pool-1; a refused item skips the assign pass.
// One item is in flight at a time; req_i.ready is high only while idle.
// A finished result sits in an output register, so the next item is
// accepted while the previous result still waits to be taken. If the
// receiver stalls past the next item's passes, the controller holds in its
// finish step until the result register frees.
// Reset: all units free (per-entry written flags cleared), units_in_use = 128,
// no result pending.
module leased_unit_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lua_req_if.sink                   req_i,
  lua_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [lua_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lua_pkg::*;

  lua_cmd_t cmd;
  lua_sts_t sts;

  // Sequencer for the two table passes.
  lua_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, counters and result register.
  lua_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .arrival_time_i (req_i.arrival_time),
    .unit_count_i   (req_i.unit_count),
    .lease_length_i (req_i.lease_length),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .out_granted_o  (rsp_o.granted),
    .out_sum_o      (rsp_o.unit_sum)
  );

endmodule

// File: hdl/lua_datapath.sv
// Datapath: busy-until table, scan counter, free/taken/sum counters, result register.
// Depends on lua_pkg.
`timescale 1ns / 1ps

module lua_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lua_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic [lua_pkg::ARR_W-1:0] arrival_time_i,
  input  logic [lua_pkg::CNT_W-1:0] unit_count_i,
  input  logic [lua_pkg::LEN_W-1:0] lease_length_i,
  input  lua_pkg::lua_cmd_t         cmd_i,
  output lua_pkg::lua_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_granted_o,
  output logic [lua_pkg::SUM_W-1:0] out_sum_o
);
  import lua_pkg::*;

  logic [CFG_W-1:0]     cfg_q;
  logic [PTR_W-1:0]     pool;

  logic [TIME_W-1:0]    arrival_q;
  logic [TIME_W-1:0]    until_q;
  logic [CNT_W-1:0]     count_q;

  logic [PTR_W-1:0]     addr_q;
  logic [IDX_W-1:0]     addr_idx;
  logic                 issue;

  logic [TIME_W-1:0]    mem [MAX_UNITS];
  logic [MAX_UNITS-1:0] written_q;
  logic [TIME_W-1:0]    rd_data_q;
  logic                 rd_written_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [TIME_W-1:0]    busy;
  logic                 is_free;

  logic [PTR_W-1:0]     free_q;
  logic [PTR_W-1:0]     taken_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 mem_we;
  logic                 enough;

  logic                 out_valid_q;
  logic                 out_granted_q;
  logic [SUM_W-1:0]     out_sum_q;

  // Config register; pool saturates at table depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign pool = (int'(cfg_q) > MAX_UNITS) ? PTR_W'(MAX_UNITS) : PTR_W'(cfg_q);

  // Request latch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load_item) begin
      count_q <= unit_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      arrival_q <= TIME_W'(arrival_time_i);
      until_q   <= TIME_W'(arrival_time_i) + TIME_W'(lease_length_i);
    end
  end

  // Scan address: one table read issued per cycle.
  assign issue    = (cmd_i.run_count || cmd_i.run_assign) && (addr_q < pool);
  assign addr_idx = addr_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load_item || cmd_i.start_assign) begin
        addr_q <= '0;
      end else if (issue) begin
        addr_q <= addr_q + PTR_W'(1);
      end
      rd_vld_q <= issue;
    end
  end

  // Compare stage, in the cycle after the read.
  assign busy    = rd_written_q ? rd_data_q : '0;
  assign is_free = busy <= arrival_q;
  assign mem_we  = rd_vld_q && cmd_i.run_assign && is_free && (int'(taken_q) < int'(count_q));
  assign enough  = int'(free_q) >= int'(count_q);

  // Table storage; write goes to the entry read in the previous cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[rd_idx_q] <= until_q;
    end
    rd_data_q <= mem[addr_idx];
    rd_idx_q  <= addr_idx;
  end

  // Per-entry written flags stand in for the cleared table after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (mem_we) begin
        written_q[rd_idx_q] <= 1'b1;
      end
      rd_written_q <= written_q[addr_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '0;
      taken_q <= '0;
      sum_q   <= '0;
    end else begin
      if (cmd_i.load_item) begin
        free_q <= '0;
      end else if (rd_vld_q && cmd_i.run_count && is_free) begin
        free_q <= free_q + PTR_W'(1);
      end
      if (cmd_i.load_item || cmd_i.start_assign) begin
        taken_q <= '0;
        sum_q   <= '0;
      end else if (mem_we) begin
        taken_q <= taken_q + PTR_W'(1);
        sum_q   <= sum_q + SUM_W'(rd_idx_q) + SUM_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_granted_q <= 1'b0;
      out_sum_q     <= '0;
    end else if (cmd_i.load_result) begin
      out_granted_q <= enough;
      out_sum_q     <= enough ? sum_q : '0;
    end
  end

  assign sts_o.pass_done = (addr_q == pool) && !rd_vld_q;
  assign sts_o.enough    = enough;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_granted_o = out_granted_q;
  assign out_sum_o     = out_sum_q;

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(taken_q) <= int'(count_q))
    else $error("more units leased than requested");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_granted_q |-> out_sum_q == '0)
    else $error("refused result carries a nonzero sum");

  a_write_in_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> enough && !cmd_i.run_count)
    else $error("table written outside a granted assign pass");

endmodule

// File: hdl/lua_ctrl.sv
// Controller: sequences the count pass, the assign pass and the result handoff.
// Depends on lua_pkg.
`timescale 1ns / 1ps

module lua_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  lua_pkg::lua_sts_t sts_i,
  output lua_pkg::lua_cmd_t cmd_o
);
  import lua_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_COUNT  = 4'b0010,
    ST_ASSIGN = 4'b0100,
    ST_FINISH = 4'b1000
  } lua_state_e;

  lua_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.load_item = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd_o.run_count = 1'b1;
        if (sts_i.pass_done) begin
          if (sts_i.enough) begin
            cmd_o.start_assign = 1'b1;
            state_d            = ST_ASSIGN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_ASSIGN: begin
        cmd_o.run_assign = 1'b1;
        if (sts_i.pass_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> sts_i.out_free)
    else $error("result loaded over an untaken result");

  a_accept_starts_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == ST_COUNT)
    else $error("accepted item did not start the count pass");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for leased_unit_allocator: first-fit leasing of numbered units.
// Depends on lua_pkg, lua_req_if, lua_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import lua_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 1500;     // long receiver stall, fills the block
  localparam int TAIL_CYCLES = 300;      // longer than one full-pool item

  typedef struct packed {
    logic             granted;
    logic [SUM_W-1:0] unit_sum;
  } lease_result_t;

  // Tracks the unit table, predicts each grant and checks results in order.
  class lease_scoreboard;
    logic [TIME_W-1:0] busy_until [MAX_UNITS];
    logic [CFG_W-1:0]  pool_reg;
    lease_result_t     expected_grants[$];
    int                mismatches;
    int                taken;
    int                grants;
    int                refusals;

    function new();
      foreach (busy_until[u]) busy_until[u] = '0;
      pool_reg   = CFG_RESET;
      mismatches = 0;
      taken      = 0;
      grants     = 0;
      refusals   = 0;
    endfunction

    function void set_pool(logic [CFG_W-1:0] value);
      pool_reg = value;
    endfunction

    function void note_request(logic [ARR_W-1:0] arrival, logic [CNT_W-1:0] count,
                               logic [LEN_W-1:0] length);
      int unsigned       pool;
      int unsigned       free_units;
      int unsigned       left;
      int unsigned       total;
      logic [TIME_W-1:0] lease_end;
      lease_result_t     res;
      pool       = (pool_reg > MAX_UNITS) ? MAX_UNITS : pool_reg;
      free_units = 0;
      lease_end  = TIME_W'(arrival) + TIME_W'(length);
      for (int u = 0; u < pool; u++) begin
        if (busy_until[u] <= TIME_W'(arrival)) free_units++;
      end
      if (free_units < count) begin
        res.granted  = 1'b0;
        res.unit_sum = '0;
      end else begin
        left  = count;
        total = 0;
        for (int u = 0; u < pool && left > 0; u++) begin
          if (busy_until[u] <= TIME_W'(arrival)) begin
            busy_until[u] = lease_end;
            total += u + 1;
            left--;
          end
        end
        res.granted  = 1'b1;
        res.unit_sum = SUM_W'(total);
      end
      expected_grants = {expected_grants, res};
    endfunction

    function void check_result(logic granted, logic [SUM_W-1:0] unit_sum);
      lease_result_t want;
      taken++;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing outstanding: granted=%0d unit_sum=%0d",
                   granted, unit_sum);
        return;
      end
      want = expected_grants.pop_front();
      if (want.granted) grants++;
      else refusals++;
      if (want.granted !== granted || want.unit_sum !== unit_sum) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: granted exp %0d got %0d, unit_sum exp %0d got %0d",
                   taken, want.granted, granted, want.unit_sum, unit_sum);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  int unsigned       cycle_count = 0;
  bit                no_idle = 1'b0;     // both sides run without gaps while set
  int unsigned       arrival_cursor = 0;
  int unsigned       pool_eff = 128;     // pool size after saturation, shapes counts
  int                pool_settings = 0;
  lease_scoreboard   sb = new();

  lua_req_if req_bus ();
  lua_rsp_if rsp_bus ();

  leased_unit_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.expected_grants.size());
    $display("[leased_unit_allocator] ERROR");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(16);
  endfunction

  // Offers one request item; drives at negedge, returns at the negedge after accept.
  task automatic offer_request(input logic [ARR_W-1:0] arrival,
                               input logic [CNT_W-1:0] count,
                               input logic [LEN_W-1:0] length);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.arrival_time <= arrival;
    req_bus.unit_count   <= count;
    req_bus.lease_length <= length;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    sb.note_request(arrival, count, length);
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic drain_requests();
    req_bus.valid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Pool size register; only called with the block idle.
  task automatic write_pool(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    sb.set_pool(value);
    pool_eff = (value > MAX_UNITS) ? MAX_UNITS : value;
    pool_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small forward steps in time with short leases, so the table keeps
  // cycling between busy and free. Rare long jumps, long leases, backward or
  // repeated times, zero counts, full-pool counts and oversized counts mixed in.
  task automatic random_request();
    int unsigned step_pick;
    int unsigned cnt_pick;
    int unsigned len_pick;
    int unsigned step;
    int unsigned cnt;
    int unsigned len;
    step_pick = $urandom_range(39);
    cnt_pick  = $urandom_range(15);
    len_pick  = $urandom_range(63);
    if (step_pick == 0) step = $urandom_range(60000, 1);
    else if (step_pick == 1) begin
      // backward in time
      step = 0;
      if (arrival_cursor > 500) arrival_cursor -= $urandom_range(500);
    end else if (step_pick == 2) step = 0;
    else step = $urandom_range(48, 1);
    if (arrival_cursor + step > 20'hFFFFF) arrival_cursor = step;
    else arrival_cursor += step;

    if (cnt_pick == 0) cnt = $urandom_range(255);
    else if (cnt_pick == 1) cnt = 0;
    else if (cnt_pick == 2) cnt = pool_eff;
    else cnt = $urandom_range(pool_eff / 4 + 1, 1);

    if (len_pick == 0) len = $urandom_range(65535);
    else if (len_pick == 1) len = 0;
    else len = $urandom_range(400, 1);

    offer_request(ARR_W'(arrival_cursor), CNT_W'(cnt), LEN_W'(len));
  endtask

  // Result side: random ready gaps, plus two long holds that back the block up
  // into its input while requests keep coming.
  initial begin
    int gap;
    int holds;
    int hold_marks [2];
    hold_marks = '{300, 900};
    holds      = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds < 2 && sb.taken >= hold_marks[holds]) begin
        holds++;
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      sb.check_result(rsp_bus.granted, rsp_bus.unit_sum);
    end
  end

  // Stimulus and verdict.
  initial begin
    int pool_plan [8];
    int item_plan [8];
    pool_plan = '{128, 1, 0, 255, 200, 8, 37, 64};
    item_plan = '{250, 150, 30, 150, 50, 250, 200, 120};

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_bus.valid        = 1'b0;
    req_bus.arrival_time = '0;
    req_bus.unit_count   = '0;
    req_bus.lease_length = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed, at the reset pool of 128 units.
    offer_request(20'd0, 8'd0, 16'd0);              // zero count: granted, sum 0
    offer_request(20'd1, 8'd128, 16'd65535);        // whole pool, longest lease
    offer_request(20'd2, 8'd1, 16'd1);              // everything busy: refused
    offer_request(20'd65536, 8'd128, 16'd1);        // free exactly at busy-until
    offer_request(20'd65536, 8'd1, 16'd5);          // repeated time, all busy
    offer_request(20'd65537, 8'd255, 16'd1);        // count above pool
    offer_request(20'd65537, 8'd1, 16'd0);          // zero-length lease
    offer_request(20'd65537, 8'd1, 16'd0);          // same unit again, still free
    offer_request(20'd65540, 8'd3, 16'd100);
    offer_request(20'd65541, 8'd2, 16'd50);
    offer_request(20'd65542, 8'd127, 16'd3);        // four short: refused
    offer_request(20'd65542, 8'd123, 16'd3);        // exactly what is free
    offer_request(20'hFFFFF, 8'd200, 16'hFFFF);     // max time, refused by count
    offer_request(20'd100, 8'd1, 16'd1);            // back in time: all busy
    offer_request(20'd70000, 8'd64, 16'd32768);     // low half
    offer_request(20'd70000, 8'd64, 16'd16384);     // upper half
    offer_request(20'd120000, 8'd128, 16'd1);       // both halves free again
    offer_request(20'd120001, 8'd129, 16'd1);       // one more than the pool
    drain_requests();
    arrival_cursor = 130000;

    // Random phases over pool sizes, including empty and above the maximum.
    // Shrinking after a busy full pool leaves upper units holding old leases.
    foreach (pool_plan[p]) begin
      write_pool(CFG_W'(pool_plan[p]));
      for (int n = 0; n < item_plan[p]; n++) begin
        if (n % 64 == 0) no_idle = ($urandom_range(2) == 0);
        random_request();
      end
      no_idle = 1'b0;
      drain_requests();
    end

    // Latest possible time with the longest lease: busy-until needs the top bit.
    write_pool(CFG_W'(128));
    pool_eff = 128;
    offer_request(20'hFFFFF, 8'd16, 16'hFFFF);
    offer_request(20'hFFFFF, 8'd128, 16'd1);
    drain_requests();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests over %0d pool settings (empty, one unit, full, oversized)",
             sb.taken, pool_settings + 1);
    $display("  %0d granted, %0d refused, %0d mismatches, %0d left outstanding",
             sb.grants, sb.refusals, sb.mismatches, sb.expected_grants.size());
    if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
      $display("[leased_unit_allocator] OK");
    end else begin
      $display("[leased_unit_allocator] ERROR");
    end
    $finish;
  end

endmodule

// File: leased_unit_allocator.f
hdl/lua_pkg.sv
hdl/lua_req_if.sv
hdl/lua_rsp_if.sv
hdl/lua_datapath.sv
hdl/lua_ctrl.sv
hdl/leased_unit_allocator.sv
tb/testbench.sv
